// ===== sv/bda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg: shared types and tables for the brightness-to-dim-alpha block
// Holds the knot table, datapath widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bda_pkg;

  // Knot table room and default number of knots in use
  localparam int KNOT_ROOM      = 64;
  localparam int KNOT_IDX_W     = 6;
  localparam int KNOT_COUNT_DEF = 20;

  // Widths of the scaled brightness, knot alpha and divider operands
  localparam int XW   = 10;
  localparam int AW   = 8;
  localparam int DVDW = 21;
  localparam int DVSW = 18;
  localparam int SUMW = 13;

  // Knot brightness, in scaled units 0..1023; unused knots read as 0
  function automatic logic [XW-1:0] knot_level(input logic [KNOT_IDX_W-1:0] idx);
    logic [XW-1:0] lv;
    unique case (idx)
      6'd0:    lv = 10'd0;
      6'd1:    lv = 10'd1;
      6'd2:    lv = 10'd2;
      6'd3:    lv = 10'd3;
      6'd4:    lv = 10'd4;
      6'd5:    lv = 10'd6;
      6'd6:    lv = 10'd10;
      6'd7:    lv = 10'd20;
      6'd8:    lv = 10'd30;
      6'd9:    lv = 10'd45;
      6'd10:   lv = 10'd70;
      6'd11:   lv = 10'd100;
      6'd12:   lv = 10'd150;
      6'd13:   lv = 10'd227;
      6'd14:   lv = 10'd300;
      6'd15:   lv = 10'd400;
      6'd16:   lv = 10'd500;
      6'd17:   lv = 10'd600;
      6'd18:   lv = 10'd800;
      6'd19:   lv = 10'd1023;
      default: lv = 10'd0;
    endcase
    return lv;
  endfunction

  // Knot alpha; unused knots read as 0
  function automatic logic [AW-1:0] knot_alpha(input logic [KNOT_IDX_W-1:0] idx);
    logic [AW-1:0] al;
    unique case (idx)
      6'd0:    al = 8'hff;
      6'd1:    al = 8'hee;
      6'd2:    al = 8'he8;
      6'd3:    al = 8'he6;
      6'd4:    al = 8'he5;
      6'd5:    al = 8'he4;
      6'd6:    al = 8'he0;
      6'd7:    al = 8'hd5;
      6'd8:    al = 8'hce;
      6'd9:    al = 8'hc6;
      6'd10:   al = 8'hb7;
      6'd11:   al = 8'had;
      6'd12:   al = 8'ha0;
      6'd13:   al = 8'h8a;
      6'd14:   al = 8'h80;
      6'd15:   al = 8'h6e;
      6'd16:   al = 8'h5b;
      6'd17:   al = 8'h50;
      6'd18:   al = 8'h38;
      6'd19:   al = 8'h18;
      default: al = 8'h00;
    endcase
    return al;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic take_first;
    logic take_last;
    logic bracket;
    logic calc;
    logic mult;
    logic bf_go;
    logic bf_take;
    logic sub_go;
    logic sub_take;
    logic sum;
    logic out_load;
  } bda_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic first;
    logic last;
    logic dy_zero;
    logic div_done;
  } bda_sts_t;

endpackage

// ===== sv/bda_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bda_div
  import bda_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DVDW-1:0] dividend_i,
  input  logic [DVSW-1:0] divisor_i,
  output logic            done_o,
  output logic [DVDW-1:0] quotient_o
);

  localparam int CntW = $clog2(DVDW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DVSW-1:0] rem_q, rem_d;
  logic [DVSW-1:0] dvs_q, dvs_d;
  logic [DVDW-1:0] quo_q, quo_d;
  logic [DVSW:0]   trial;
  logic            fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[DVDW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DVDW - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DVSW'(trial - {1'b0, dvs_q}) : trial[DVSW-1:0];
      quo_d = {quo_q[DVDW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/bda_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_dpath: datapath of the brightness-to-dim-alpha block
// Scales the brightness, walks the knot table, forms the interpolation
// terms, runs both divisions on one shared divider and clamps the sum.
// ----------------------------------------------------------------------------
module bda_dpath
  import bda_pkg::*;
#(
  parameter int KNOT_COUNT = KNOT_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bda_cmd_t      cmd_i,
  output bda_sts_t      sts_o,
  input  logic [AW-1:0] brightness_level_i,
  output logic [AW-1:0] dim_alpha_o
);

  localparam int IdxW = (KNOT_COUNT > 1) ? $clog2(KNOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(KNOT_COUNT - 1);

  logic [IdxW-1:0]        idx_q;
  logic [XW-1:0]          x_q;
  logic [XW-1:0]          xa_q, xb_q;
  logic [AW-1:0]          ya_q, yb_q;
  logic signed [AW:0]     dy_q;
  logic signed [XW:0]     dx_q, u_q, v_q, w_q;
  logic signed [19:0]     nbf_q, dsub_q;
  logic signed [21:0]     np_q;
  logic [DVDW-1:0]        bf_mag_q, sub_mag_q;
  logic                   bf_neg_q, sub_neg_q;
  logic [AW-1:0]          res_q, dim_alpha_q;

  logic [9:0]             b3;
  logic [1:0]             xfrac;
  logic [XW-1:0]          lv_cur, lv_prev;
  logic [KNOT_IDX_W-1:0]  idx_ext, idx_prev;
  logic signed [19:0]     nbf_prod, dsub_prod;
  logic signed [21:0]     np_prod;
  logic [19:0]            nbf_abs, dsub_abs;
  logic [21:0]            np_abs;
  logic [XW:0]            dx_abs;
  logic                   div_start;
  logic [DVDW-1:0]        div_dvd, div_quo;
  logic [DVSW-1:0]        div_dvs;
  logic                   div_done;
  logic [DVDW:0]          bf_inc;
  logic [SUMW-1:0]        half_mag, subt_mag;
  logic signed [SUMW-1:0] half_s, subt_s, sum_s;
  logic [AW-1:0]          clamp;

  // Scale b*1023/255 as 4b plus floor(3b/255)
  assign b3    = 10'({2'b00, brightness_level_i} + {1'b0, brightness_level_i, 1'b0});
  assign xfrac = 2'(b3 >= 10'd255) + 2'(b3 >= 10'd510) + 2'(b3 >= 10'd765);

  // Knot lookups at the search position and the one before it
  assign idx_ext  = KNOT_IDX_W'(idx_q);
  assign idx_prev = idx_ext - 1'b1;
  assign lv_cur   = knot_level(idx_ext);
  assign lv_prev  = knot_level(idx_prev);

  assign sts_o.hit      = lv_cur >= x_q;
  assign sts_o.first    = idx_q == '0;
  assign sts_o.last     = idx_q == LastIdx;
  assign sts_o.dy_zero  = dy_q == '0;
  assign sts_o.div_done = div_done;

  // Products of the interpolation terms; all stay well inside their widths
  assign nbf_prod  = 20'(dy_q * u_q) <<< 1;
  assign np_prod   = 22'(u_q * v_q) <<< 1;
  assign dsub_prod = 20'(dy_q * w_q);

  // Magnitudes fed to the unsigned divider
  assign nbf_abs  = nbf_q[19]  ? 20'(-nbf_q)  : nbf_q;
  assign np_abs   = np_q[21]   ? 22'(-np_q)   : np_q;
  assign dsub_abs = dsub_q[19] ? 20'(-dsub_q) : dsub_q;
  assign dx_abs   = dx_q[XW]   ? 11'(-dx_q)   : dx_q;

  assign div_start = cmd_i.bf_go | cmd_i.sub_go;
  assign div_dvd   = cmd_i.sub_go ? np_abs[DVDW-1:0] : DVDW'(nbf_abs);
  assign div_dvs   = cmd_i.sub_go ? dsub_abs[DVSW-1:0] : DVSW'(dx_abs);

  bda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Round bf/2 half away from zero, then add ya and the correction
  assign bf_inc   = {1'b0, bf_mag_q} + 1'b1;
  assign half_mag = SUMW'(bf_inc[DVDW:1]);
  assign subt_mag = SUMW'(sub_mag_q);
  assign half_s   = bf_neg_q ? -$signed(half_mag) : $signed(half_mag);
  assign subt_s   = sub_neg_q ? -$signed(subt_mag) : $signed(subt_mag);
  assign sum_s    = $signed({{(SUMW-AW){1'b0}}, ya_q}) + half_s + subt_s;

  always_comb begin
    priority if (sum_s < 0) begin
      clamp = '0;
    end else if (sum_s > 255) begin
      clamp = '1;
    end else begin
      clamp = sum_s[AW-1:0];
    end
  end

  // Search position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= {brightness_level_i, 2'b00} + XW'(xfrac);
    end
    if (cmd_i.take_first) begin
      res_q <= knot_alpha('0);
    end
    if (cmd_i.take_last) begin
      res_q <= knot_alpha(KNOT_IDX_W'(LastIdx));
    end
    if (cmd_i.bracket) begin
      xa_q <= lv_prev;
      xb_q <= lv_cur;
      ya_q <= knot_alpha(idx_prev);
      yb_q <= knot_alpha(idx_ext);
    end
    if (cmd_i.calc) begin
      dy_q <= $signed({1'b0, yb_q}) - $signed({1'b0, ya_q});
      dx_q <= $signed({1'b0, xb_q}) - $signed({1'b0, xa_q});
      u_q  <= $signed({1'b0, x_q}) - $signed({1'b0, xa_q});
      v_q  <= $signed({1'b0, x_q}) - $signed({1'b0, xb_q});
      w_q  <= $signed({1'b0, xa_q}) - $signed({1'b0, xb_q});
    end
    if (cmd_i.mult) begin
      nbf_q     <= nbf_prod;
      np_q      <= np_prod;
      dsub_q    <= dsub_prod;
      sub_mag_q <= '0;
      sub_neg_q <= 1'b0;
    end
    if (cmd_i.bf_take) begin
      bf_mag_q <= div_quo;
      bf_neg_q <= nbf_q[19] ^ dx_q[XW];
    end
    if (cmd_i.sub_take) begin
      sub_mag_q <= div_quo;
      sub_neg_q <= np_q[21] ^ dsub_q[19];
    end
    if (cmd_i.sum) begin
      res_q <= clamp;
    end
    if (cmd_i.out_load) begin
      dim_alpha_q <= res_q;
    end
  end

  assign dim_alpha_o = dim_alpha_q;

endmodule

// ===== sv/bda_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_ctrl: controller of the brightness-to-dim-alpha block
// Sequences search, interpolation and division and owns both handshakes.
// ----------------------------------------------------------------------------
module bda_ctrl
  import bda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bda_cmd_t cmd_o,
  input  bda_sts_t sts_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SEARCH   = 4'd1;
  localparam logic [3:0] S_CALC     = 4'd2;
  localparam logic [3:0] S_MULT     = 4'd3;
  localparam logic [3:0] S_BF_GO    = 4'd4;
  localparam logic [3:0] S_BF_WAIT  = 4'd5;
  localparam logic [3:0] S_SUB_GO   = 4'd6;
  localparam logic [3:0] S_SUB_WAIT = 4'd7;
  localparam logic [3:0] S_SUM      = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.hit) begin
          if (sts_i.first) begin
            cmd_o.take_first = 1'b1;
            state_d          = S_OUT;
          end else begin
            cmd_o.bracket = 1'b1;
            state_d       = S_CALC;
          end
        end else if (sts_i.last) begin
          cmd_o.take_last = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_BF_GO;
      end
      S_BF_GO: begin
        cmd_o.bf_go = 1'b1;
        state_d     = S_BF_WAIT;
      end
      S_BF_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.bf_take = 1'b1;
          state_d       = sts_i.dy_zero ? S_SUM : S_SUB_GO;
        end
      end
      S_SUB_GO: begin
        cmd_o.sub_go = 1'b1;
        state_d      = S_SUB_WAIT;
      end
      S_SUB_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.sub_take = 1'b1;
          state_d        = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // Hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/brightness_to_dim_alpha.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brightness_to_dim_alpha: dimming overlay alpha from panel brightness
// Piecewise interpolation over a fixed knot table with a quadratic
// correction term, clamped to 0..255.
// ----------------------------------------------------------------------------
//   Channel | Handshake                 | Payload
//   --------+---------------------------+----------------------------
//   in      | in_valid_i / in_ready_o   | brightness_level_i [7:0]
//   out     | out_valid_o / out_ready_i | dim_alpha_o [7:0]
//
// One beat at a time. The knot search visits one knot per step (up to
// KNOT_COUNT knots); interpolation then runs one or two divisions on the
// shared divider (start, shift steps, done). A new beat is taken while the
// previous result still waits in the output register; a stalled output holds
// the next result back. Reset clears the control state; datapath working
// registers need no reset.
// ----------------------------------------------------------------------------
module brightness_to_dim_alpha
  import bda_pkg::*;
#(
  parameter int KNOT_COUNT = KNOT_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [AW-1:0] brightness_level_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [AW-1:0] dim_alpha_o
);

  bda_cmd_t cmd;
  bda_sts_t sts;

  bda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bda_dpath #(
    .KNOT_COUNT (KNOT_COUNT)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .brightness_level_i (brightness_level_i),
    .dim_alpha_o        (dim_alpha_o)
  );

endmodule

// ===== bench/bda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_checker: scoreboard for the brightness-to-dim-alpha block
// Watches both channels, works out the alpha for each brightness beat taken
// on the input, and compares every output beat with the oldest pending alpha.
// ----------------------------------------------------------------------------
module bda_checker
  import bda_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [AW-1:0] brightness_level_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  logic [AW-1:0] dim_alpha_i,
  output int            fail_count_o,
  output int            pending_o
);

  // Knot table: scaled brightness and alpha per knot
  localparam int NKNOTS = KNOT_COUNT_DEF;
  localparam longint KNOT_X [NKNOTS] = '{
    0, 1, 2, 3, 4, 6, 10, 20, 30, 45,
    70, 100, 150, 227, 300, 400, 500, 600, 800, 1023
  };
  localparam longint KNOT_Y [NKNOTS] = '{
    255, 238, 232, 230, 229, 228, 224, 213, 206, 198,
    183, 173, 160, 138, 128, 110, 91, 80, 56, 24
  };

  logic [AW-1:0] alpha_queue [$];

  // Interpolate between two knots with a quadratic correction
  function automatic longint knot_blend(longint x, longint xa, longint xb,
                                        longint ya, longint yb);
    longint dy;
    longint dx;
    longint bf;
    longint corr;
    dy   = yb - ya;
    dx   = xb - xa;
    corr = 0;
    if (dx == 0) return ya;
    bf = (2 * dy * (x - xa)) / dx;
    if (dy != 0) corr = ((2 * (x - xa) * (x - xb)) / dy) / (xa - xb);
    return ya + bf / 2 + bf % 2 + corr;
  endfunction

  // Alpha expected for one brightness level
  function automatic logic [AW-1:0] alpha_of_level(logic [AW-1:0] lvl);
    longint x;
    longint r;
    int     k;
    x = (longint'(lvl) * 1023) / 255;
    k = NKNOTS;
    for (int i = 0; i < NKNOTS; i++) begin
      if (KNOT_X[i] >= x) begin
        k = i;
        break;
      end
    end
    if (k == 0) r = KNOT_Y[0];
    else if (k == NKNOTS) r = KNOT_Y[NKNOTS-1];
    else r = knot_blend(x, KNOT_X[k-1], KNOT_X[k], KNOT_Y[k-1], KNOT_Y[k]);
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[AW-1:0];
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Predict on input beats, compare on output beats
  always @(posedge clk_i) begin
    logic [AW-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        alpha_queue.push_back(alpha_of_level(brightness_level_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (alpha_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected dim_alpha beat 0x%02h", dim_alpha_i));
        end else begin
          want = alpha_queue.pop_front();
          if (dim_alpha_i !== want) begin
            report_mismatch($sformatf("dim_alpha 0x%02h, expected 0x%02h",
                                      dim_alpha_i, want));
          end
        end
      end
      pending_o = alpha_queue.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for brightness_to_dim_alpha
// Sends directed and random brightness levels through phases of sender
// gaps and receiver stalls, including one long output hold-off, while the
// checker predicts and compares every alpha.
// ----------------------------------------------------------------------------
module tb_top;
  import bda_pkg::*;

  typedef enum int {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH
  } phase_e;

  localparam int     RAND_PER_PHASE = 100;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     DRAIN_CYCLES   = 120;
  localparam longint CYCLE_LIMIT    = 400000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [AW-1:0] brightness_level_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [AW-1:0] dim_alpha_o;

  int     fail_count;
  int     pending;
  longint cycles;
  phase_e phase;
  bit     hold_req;

  brightness_to_dim_alpha dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .brightness_level_i (brightness_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .dim_alpha_o        (dim_alpha_o)
  );

  bda_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .brightness_level_i (brightness_level_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .dim_alpha_i        (dim_alpha_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int src_idle_pct(phase_e ph);
    case (ph)
      PH_SRC_IDLE: return 64;
      PH_BOTH:     return 10;
      default:     return 0;
    endcase
  endfunction

  function automatic int snk_stall_pct(phase_e ph);
    case (ph)
      PH_SNK_STALL: return 64;
      PH_BOTH:      return 10;
      default:      return 0;
    endcase
  endfunction

  // Offer one brightness beat and hold it until taken; call at a rising edge
  task automatic send_level(logic [AW-1:0] lvl);
    bit ready_seen;
    while (chance(src_idle_pct(phase))) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    brightness_level_i <= lvl;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    int held;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= !chance(snk_stall_pct(phase));
      end
    end
  end

  // Reset, stimulus and verdict
  initial begin
    logic [AW-1:0] directed [$];
    directed = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd11, 8'd18, 8'd25,
                 8'd37, 8'd56, 8'd57, 8'd64, 8'd75, 8'd85, 8'd100, 8'd125,
                 8'd128, 8'd150, 8'd170, 8'd200, 8'd254, 8'd255};
    phase              = PH_FREE;
    hold_req           = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    brightness_level_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Knots, spans between knots and both ends of the range
    foreach (directed[i]) send_level(directed[i]);

    // Random levels through every phase, free-running and idling
    for (int p = PH_FREE; p <= PH_BOTH; p++) begin
      phase = phase_e'(p);
      if (phase == PH_SNK_STALL) hold_req = 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_level(AW'($urandom_range(255, 0)));
      end
    end
    in_valid_i <= 1'b0;

    // Let the checker see the last input beat, drain, then allow for stray beats
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
